@@ hdl/sptc_pkg.sv @@
// Shared constants, codes and helpers for the shape pair collision test.
// No dependencies; imported by every module of the block.
package sptc_pkg;

    // Size fields (radius, width, height) are unsigned Q12.8
    localparam int SIZE_WIDTH  = 20;
    // Sum of two radii
    localparam int RAD_WIDTH   = SIZE_WIDTH + 1;
    // Squared radius sum
    localparam int LIMIT_WIDTH = 2 * RAD_WIDTH;

    typedef logic t_kind;
    localparam t_kind KIND_CIRCLE = 1'b0;
    localparam t_kind KIND_RECT   = 1'b1;

    // Pair codes: {first_kind, second_kind}
    typedef logic [1:0] t_pair;
    localparam t_pair PAIR_CIRC_CIRC = {KIND_CIRCLE, KIND_CIRCLE};
    localparam t_pair PAIR_CIRC_RECT = {KIND_CIRCLE, KIND_RECT};
    localparam t_pair PAIR_RECT_CIRC = {KIND_RECT, KIND_CIRCLE};
    localparam t_pair PAIR_RECT_RECT = {KIND_RECT, KIND_RECT};

    // Width of a signed rectangle edge: corner plus size without overflow
    function automatic int edge_width(input int coord_width);
        return ((coord_width > RAD_WIDTH) ? coord_width : RAD_WIDTH) + 1;
    endfunction

    // Width of the final compare: sum of two squares against the limit
    function automatic int cmp_width(input int coord_width);
        return ((2 * coord_width + 1) > LIMIT_WIDTH) ? (2 * coord_width + 1) : LIMIT_WIDTH;
    endfunction

endpackage

@@ hdl/sptc_channels.sv @@
// Valid/ready channel interfaces for the shape pair collision test.
// Depends on sptc_pkg for the size field width.
interface sptc_pair_if
    import sptc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic                          first_kind;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic        [SIZE_WIDTH-1:0]  first_size_a;
    logic        [SIZE_WIDTH-1:0]  first_size_b;
    logic                          second_kind;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic        [SIZE_WIDTH-1:0]  second_size_a;
    logic        [SIZE_WIDTH-1:0]  second_size_b;

    modport source (
        output valid, first_kind, first_x, first_y, first_size_a, first_size_b,
               second_kind, second_x, second_y, second_size_a, second_size_b,
        input  ready
    );
    modport sink (
        input  valid, first_kind, first_x, first_y, first_size_a, first_size_b,
               second_kind, second_x, second_y, second_size_a, second_size_b,
        output ready
    );
endinterface

interface sptc_result_if;
    logic valid;
    logic ready;
    logic colliding;

    modport source (output valid, colliding, input ready);
    modport sink (input valid, colliding, output ready);
endinterface

@@ hdl/shape_pair_collision_test.sv @@
// Shape pair collision test: four register stages, result valid from the stage 4 output register.
// One request per cycle unless stalled; each stage advances when the next is empty or moving,
// so bubbles collapse and a stalled output still lets earlier stages fill.
// Stages: prep/edges, clamp + radius square, axis squares, sum-compare into output register.
// Reset (i_rst_n, synchronous, active low) clears the stage valid bits only.
// Depends on sptc_pkg, sptc_channels, sptc_prep, sptc_clamp, sptc_square.
module shape_pair_collision_test
    import sptc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sptc_pair_if.sink             i_pair,
    sptc_result_if.source         o_result
);
    localparam int EW = edge_width(COORD_WIDTH);
    localparam int CW = cmp_width(COORD_WIDTH);

    // Stage valid bits, one per register stage
    logic r_v1, r_v2, r_v3, r_v4;
    // Stage advance enables, computed back from the output
    logic en1, en2, en3, en4;

    // Stage 1 -> 2
    logic                 s1_rect_pair;
    logic signed [EW-1:0] s1_cx, s1_cy;
    logic [RAD_WIDTH-1:0] s1_rad;
    logic signed [EW-1:0] s1_lo_x, s1_hi_x, s1_lo_y, s1_hi_y;
    logic signed [EW-1:0] s1_p_lo_x, s1_p_hi_x, s1_p_lo_y, s1_p_hi_y;

    // Stage 2 -> 3
    logic                   s2_rect_pair, s2_apart;
    logic [COORD_WIDTH-1:0] s2_mag_x, s2_mag_y;
    logic [LIMIT_WIDTH-1:0] s2_limit;

    // Stage 3 -> 4
    logic                     s3_rect_pair, s3_apart;
    logic [2*COORD_WIDTH-1:0] s3_sq_x, s3_sq_y;
    logic [LIMIT_WIDTH-1:0]   s3_limit;

    // Final compare
    logic [CW-1:0] dist_sum;
    logic [CW-1:0] limit_ext;
    logic          r_colliding, n_colliding;

    // A stage loads when it is empty or its content moves on this edge.
    assign en4 = !r_v4 || o_result.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_pair.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_pair.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage 1: pick circle vs. target rectangle, form edges
    sptc_prep #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_prep (
        .i_clk           (i_clk),
        .i_en            (en1),
        .i_first_kind    (i_pair.first_kind),
        .i_first_x       (i_pair.first_x),
        .i_first_y       (i_pair.first_y),
        .i_first_size_a  (i_pair.first_size_a),
        .i_first_size_b  (i_pair.first_size_b),
        .i_second_kind   (i_pair.second_kind),
        .i_second_x      (i_pair.second_x),
        .i_second_y      (i_pair.second_y),
        .i_second_size_a (i_pair.second_size_a),
        .i_second_size_b (i_pair.second_size_b),
        .o_rect_pair     (s1_rect_pair),
        .o_cx            (s1_cx),
        .o_cy            (s1_cy),
        .o_rad           (s1_rad),
        .o_lo_x          (s1_lo_x),
        .o_hi_x          (s1_hi_x),
        .o_lo_y          (s1_lo_y),
        .o_hi_y          (s1_hi_y),
        .o_p_lo_x        (s1_p_lo_x),
        .o_p_hi_x        (s1_p_hi_x),
        .o_p_lo_y        (s1_p_lo_y),
        .o_p_hi_y        (s1_p_hi_y)
    );

    // Stage 2: clamp distances, radius square, separation test
    sptc_clamp #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_clamp (
        .i_clk       (i_clk),
        .i_en        (en2),
        .i_rect_pair (s1_rect_pair),
        .i_cx        (s1_cx),
        .i_cy        (s1_cy),
        .i_rad       (s1_rad),
        .i_lo_x      (s1_lo_x),
        .i_hi_x      (s1_hi_x),
        .i_lo_y      (s1_lo_y),
        .i_hi_y      (s1_hi_y),
        .i_p_lo_x    (s1_p_lo_x),
        .i_p_hi_x    (s1_p_hi_x),
        .i_p_lo_y    (s1_p_lo_y),
        .i_p_hi_y    (s1_p_hi_y),
        .o_rect_pair (s2_rect_pair),
        .o_apart     (s2_apart),
        .o_mag_x     (s2_mag_x),
        .o_mag_y     (s2_mag_y),
        .o_limit     (s2_limit)
    );

    // Stage 3: per-axis squares
    sptc_square #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_square (
        .i_clk       (i_clk),
        .i_en        (en3),
        .i_rect_pair (s2_rect_pair),
        .i_apart     (s2_apart),
        .i_mag_x     (s2_mag_x),
        .i_mag_y     (s2_mag_y),
        .i_limit     (s2_limit),
        .o_rect_pair (s3_rect_pair),
        .o_apart     (s3_apart),
        .o_sq_x      (s3_sq_x),
        .o_sq_y      (s3_sq_y),
        .o_limit     (s3_limit)
    );

    // Stage 4: exact sum of squares against the squared radius (strict),
    // or the separation result for two rectangles.
    always_comb begin
        dist_sum    = CW'(s3_sq_x) + CW'(s3_sq_y);
        limit_ext   = CW'(s3_limit);
        n_colliding = s3_rect_pair ? !s3_apart : (dist_sum < limit_ext);
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_colliding <= n_colliding;
        end
    end

    assign o_result.valid     = r_v4;
    assign o_result.colliding = r_colliding;

`ifndef SYNTH
    // Occupancy tracks accepted minus delivered requests
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(!i_rst_n) |->
        ($countones({r_v1, r_v2, r_v3, r_v4}) ==
         $past($countones({r_v1, r_v2, r_v3, r_v4})) +
         $past(i_pair.valid && i_pair.ready) - $past(o_result.valid && o_result.ready)))
        else $error("pipeline occupancy mismatch");

    // An empty pipeline always takes a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v1 || r_v2 || r_v3 || r_v4) |-> i_pair.ready)
        else $error("ready low with an empty pipeline");

    // Rectangle pairs produce the inverted separation flag
    a_rect_pair_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && en4 && s3_rect_pair) |=> (r_colliding == !$past(s3_apart)))
        else $error("rectangle pair result wrong");

    // A blocked stage 2 holds its distances
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en3) |=> (r_v2 && $stable(s2_mag_x) && $stable(s2_mag_y)))
        else $error("stalled stage 2 changed");
`endif

endmodule

@@ hdl/sptc_prep.sv @@
// Stage 1: orders the pair into circle and target rectangle, builds rectangle edges.
// Depends on sptc_pkg.
module sptc_prep
    import sptc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                        i_clk,
    input  logic                                        i_en,
    input  logic                                        i_first_kind,
    input  logic signed [COORD_WIDTH-1:0]               i_first_x,
    input  logic signed [COORD_WIDTH-1:0]               i_first_y,
    input  logic        [SIZE_WIDTH-1:0]                i_first_size_a,
    input  logic        [SIZE_WIDTH-1:0]                i_first_size_b,
    input  logic                                        i_second_kind,
    input  logic signed [COORD_WIDTH-1:0]               i_second_x,
    input  logic signed [COORD_WIDTH-1:0]               i_second_y,
    input  logic        [SIZE_WIDTH-1:0]                i_second_size_a,
    input  logic        [SIZE_WIDTH-1:0]                i_second_size_b,
    output logic                                        o_rect_pair,
    output logic signed [edge_width(COORD_WIDTH)-1:0]   o_cx,
    output logic signed [edge_width(COORD_WIDTH)-1:0]   o_cy,
    output logic        [RAD_WIDTH-1:0]                 o_rad,
    output logic signed [edge_width(COORD_WIDTH)-1:0]   o_lo_x,
    output logic signed [edge_width(COORD_WIDTH)-1:0]   o_hi_x,
    output logic signed [edge_width(COORD_WIDTH)-1:0]   o_lo_y,
    output logic signed [edge_width(COORD_WIDTH)-1:0]   o_hi_y,
    output logic signed [edge_width(COORD_WIDTH)-1:0]   o_p_lo_x,
    output logic signed [edge_width(COORD_WIDTH)-1:0]   o_p_hi_x,
    output logic signed [edge_width(COORD_WIDTH)-1:0]   o_p_lo_y,
    output logic signed [edge_width(COORD_WIDTH)-1:0]   o_p_hi_y
);
    localparam int EW = edge_width(COORD_WIDTH);

    logic signed [EW-1:0] x1, y1, x2, y2, w1, h1, w2, h2;
    logic signed [EW-1:0] x1_hi, y1_hi, x2_hi, y2_hi;

    logic                 r_rect_pair, n_rect_pair;
    logic signed [EW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [RAD_WIDTH-1:0] r_rad, n_rad;
    logic signed [EW-1:0] r_lo_x, n_lo_x, r_hi_x, n_hi_x;
    logic signed [EW-1:0] r_lo_y, n_lo_y, r_hi_y, n_hi_y;
    logic signed [EW-1:0] r_p_lo_x, r_p_hi_x, r_p_lo_y, r_p_hi_y;

    always_comb begin
        x1 = EW'(i_first_x);
        y1 = EW'(i_first_y);
        x2 = EW'(i_second_x);
        y2 = EW'(i_second_y);
        w1 = $signed(EW'(i_first_size_a));
        h1 = $signed(EW'(i_first_size_b));
        w2 = $signed(EW'(i_second_size_a));
        h2 = $signed(EW'(i_second_size_b));
        x1_hi = x1 + w1;
        y1_hi = y1 + h1;
        x2_hi = x2 + w2;
        y2_hi = y2 + h2;
    end

    // When both are circles, the second is treated as a zero-size rectangle at its centre,
    // with the two radii folded into one.
    always_comb begin
        n_rect_pair = 1'b0;
        n_cx   = x1;
        n_cy   = y1;
        n_rad  = RAD_WIDTH'(i_first_size_a);
        n_lo_x = x2;
        n_hi_x = x2_hi;
        n_lo_y = y2;
        n_hi_y = y2_hi;
        case ({i_first_kind, i_second_kind})
            PAIR_CIRC_CIRC: begin
                n_rad  = RAD_WIDTH'(i_first_size_a) + RAD_WIDTH'(i_second_size_a);
                n_hi_x = x2;
                n_hi_y = y2;
            end
            PAIR_CIRC_RECT: begin
            end
            PAIR_RECT_CIRC: begin
                n_cx   = x2;
                n_cy   = y2;
                n_rad  = RAD_WIDTH'(i_second_size_a);
                n_lo_x = x1;
                n_hi_x = x1_hi;
                n_lo_y = y1;
                n_hi_y = y1_hi;
            end
            PAIR_RECT_RECT: begin
                n_rect_pair = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rect_pair <= n_rect_pair;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_rad       <= n_rad;
            r_lo_x      <= n_lo_x;
            r_hi_x      <= n_hi_x;
            r_lo_y      <= n_lo_y;
            r_hi_y      <= n_hi_y;
            r_p_lo_x    <= x1;
            r_p_hi_x    <= x1_hi;
            r_p_lo_y    <= y1;
            r_p_hi_y    <= y1_hi;
        end
    end

    assign o_rect_pair = r_rect_pair;
    assign o_cx        = r_cx;
    assign o_cy        = r_cy;
    assign o_rad       = r_rad;
    assign o_lo_x      = r_lo_x;
    assign o_hi_x      = r_hi_x;
    assign o_lo_y      = r_lo_y;
    assign o_hi_y      = r_hi_y;
    assign o_p_lo_x    = r_p_lo_x;
    assign o_p_hi_x    = r_p_hi_x;
    assign o_p_lo_y    = r_p_lo_y;
    assign o_p_hi_y    = r_p_hi_y;

endmodule

@@ hdl/sptc_clamp.sv @@
// Stage 2: clamps the centre onto the rectangle, squares the radius,
// and tests rectangle separation. Depends on sptc_pkg.
module sptc_clamp
    import sptc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic                                      i_rect_pair,
    input  logic signed [edge_width(COORD_WIDTH)-1:0] i_cx,
    input  logic signed [edge_width(COORD_WIDTH)-1:0] i_cy,
    input  logic        [RAD_WIDTH-1:0]               i_rad,
    input  logic signed [edge_width(COORD_WIDTH)-1:0] i_lo_x,
    input  logic signed [edge_width(COORD_WIDTH)-1:0] i_hi_x,
    input  logic signed [edge_width(COORD_WIDTH)-1:0] i_lo_y,
    input  logic signed [edge_width(COORD_WIDTH)-1:0] i_hi_y,
    input  logic signed [edge_width(COORD_WIDTH)-1:0] i_p_lo_x,
    input  logic signed [edge_width(COORD_WIDTH)-1:0] i_p_hi_x,
    input  logic signed [edge_width(COORD_WIDTH)-1:0] i_p_lo_y,
    input  logic signed [edge_width(COORD_WIDTH)-1:0] i_p_hi_y,
    output logic                                      o_rect_pair,
    output logic                                      o_apart,
    output logic        [COORD_WIDTH-1:0]             o_mag_x,
    output logic        [COORD_WIDTH-1:0]             o_mag_y,
    output logic        [LIMIT_WIDTH-1:0]             o_limit
);
    localparam int EW = edge_width(COORD_WIDTH);

    logic signed [EW:0]        above_x, below_x, above_y, below_y;
    logic [COORD_WIDTH-1:0]    r_mag_x, n_mag_x, r_mag_y, n_mag_y;
    logic [LIMIT_WIDTH-1:0]    r_limit, n_limit;
    logic                      r_apart, n_apart;
    logic                      r_rect_pair;

    // Distance to the clamped point never exceeds the centre-to-corner span,
    // so COORD_WIDTH bits hold it.
    always_comb begin
        above_x = (EW + 1)'(i_cx) - (EW + 1)'(i_hi_x);
        below_x = (EW + 1)'(i_lo_x) - (EW + 1)'(i_cx);
        above_y = (EW + 1)'(i_cy) - (EW + 1)'(i_hi_y);
        below_y = (EW + 1)'(i_lo_y) - (EW + 1)'(i_cy);

        if (i_cx > i_hi_x) begin
            n_mag_x = above_x[COORD_WIDTH-1:0];
        end else if (i_cx < i_lo_x) begin
            n_mag_x = below_x[COORD_WIDTH-1:0];
        end else begin
            n_mag_x = '0;
        end

        if (i_cy > i_hi_y) begin
            n_mag_y = above_y[COORD_WIDTH-1:0];
        end else if (i_cy < i_lo_y) begin
            n_mag_y = below_y[COORD_WIDTH-1:0];
        end else begin
            n_mag_y = '0;
        end

        n_limit = LIMIT_WIDTH'(i_rad) * LIMIT_WIDTH'(i_rad);

        // touching edges are not apart
        n_apart = (i_p_hi_x < i_lo_x) || (i_p_lo_x > i_hi_x) ||
                  (i_p_hi_y < i_lo_y) || (i_p_lo_y > i_hi_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rect_pair <= i_rect_pair;
            r_apart     <= n_apart;
            r_mag_x     <= n_mag_x;
            r_mag_y     <= n_mag_y;
            r_limit     <= n_limit;
        end
    end

    assign o_rect_pair = r_rect_pair;
    assign o_apart     = r_apart;
    assign o_mag_x     = r_mag_x;
    assign o_mag_y     = r_mag_y;
    assign o_limit     = r_limit;

endmodule

@@ hdl/sptc_square.sv @@
// Stage 3: squares the per-axis distances, one multiplier per axis.
// Depends on sptc_pkg.
module sptc_square
    import sptc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_rect_pair,
    input  logic                         i_apart,
    input  logic [COORD_WIDTH-1:0]       i_mag_x,
    input  logic [COORD_WIDTH-1:0]       i_mag_y,
    input  logic [LIMIT_WIDTH-1:0]       i_limit,
    output logic                         o_rect_pair,
    output logic                         o_apart,
    output logic [2*COORD_WIDTH-1:0]     o_sq_x,
    output logic [2*COORD_WIDTH-1:0]     o_sq_y,
    output logic [LIMIT_WIDTH-1:0]       o_limit
);
    logic [2*COORD_WIDTH-1:0] r_sq_x, n_sq_x, r_sq_y, n_sq_y;
    logic                     r_rect_pair, r_apart;
    logic [LIMIT_WIDTH-1:0]   r_limit;

    always_comb begin
        n_sq_x = (2 * COORD_WIDTH)'(i_mag_x) * (2 * COORD_WIDTH)'(i_mag_x);
        n_sq_y = (2 * COORD_WIDTH)'(i_mag_y) * (2 * COORD_WIDTH)'(i_mag_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rect_pair <= i_rect_pair;
            r_apart     <= i_apart;
            r_sq_x      <= n_sq_x;
            r_sq_y      <= n_sq_y;
            r_limit     <= i_limit;
        end
    end

    assign o_rect_pair = r_rect_pair;
    assign o_apart     = r_apart;
    assign o_sq_x      = r_sq_x;
    assign o_sq_y      = r_sq_y;
    assign o_limit     = r_limit;

endmodule
